// ===== rtl/core/crcws_pkg.sv =====
// ---------------------------------------------------------------------------
// CRC-64 word stream package
// Widths, polynomial and the bit-level update shared by the CRC stream core.
// ---------------------------------------------------------------------------
`default_nettype none

package crcws_pkg;

  localparam int unsigned CrcWidth   = 64;
  localparam int unsigned WordBytes  = 8;
  localparam int unsigned WordWidth  = 8 * WordBytes;
  localparam int unsigned CountWidth = 4;
  // data word then byte count, padded to whole bytes
  localparam int unsigned InPackedWidth = WordWidth + CountWidth;
  localparam int unsigned InDataWidth   = ((InPackedWidth + 7) / 8) * 8;

  localparam logic [CrcWidth-1:0] CrcPoly = 64'hC96C5795D7870F42;

  typedef logic [CrcWidth-1:0]   crc_t;
  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [CountWidth-1:0] count_t;

  // Reflected update of the running CRC by one message byte.
  function automatic crc_t absorb_byte(input crc_t crc, input logic [7:0] byte_val);
    crc_t c;
    c = crc ^ {{(CrcWidth-8){1'b0}}, byte_val};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crc64_reflected_word_stream_unit.sv =====
// ---------------------------------------------------------------------------
// CRC-64 reflected word stream unit
// Reflected CRC-64 (poly 0xC96C5795D7870F42, zero init, no final XOR) over
// a stream of up to eight bytes per word.
// ---------------------------------------------------------------------------
// Takes one word per cycle unless the input side stalls. Each accepted word
// is held in an input register, its valid bytes (least significant first) are
// folded into the running CRC by a flattened XOR network, and a word with tlast
// loads the finished CRC into the output register, clearing the running CRC to zero.
// An accepted last word reaches tvalid via the input register, then the output register.
// The input side stalls only while a finished CRC waits in the output
// register and the word in the input register is itself a last word.
`default_nettype none

module crc64_reflected_word_stream_unit (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                s_axis_tvalid,
  output var logic                                s_axis_tready,
  // [63:0] data_word, [67:64] byte_count, [71:68] zero
  input  var logic [crcws_pkg::InDataWidth-1:0]   s_axis_tdata,
  input  var logic                                s_axis_tlast,
  output var logic                                m_axis_tvalid,
  input  var logic                                m_axis_tready,
  // [63:0] crc_value
  output var crcws_pkg::crc_t                     m_axis_tdata
);
  import crcws_pkg::*;

  logic   in_valid_q, in_valid_d;
  word_t  in_data_q;
  count_t in_count_q;
  logic   in_last_q;
  crc_t   run_crc_q, run_crc_d;
  logic   out_valid_q, out_valid_d;
  crc_t   out_crc_q;
  crc_t   next_crc;
  logic   s_fire, advance;

  crcws_absorb u_absorb (
    .crc_i   (run_crc_q),
    .data_i  (in_data_q),
    .count_i (in_count_q),
    .crc_o   (next_crc)
  );

  // A held word advances unless it must hand a CRC to a full output register that is not being read.
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    run_crc_d   = run_crc_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      in_valid_d = 1'b0;
      if (in_last_q) begin
        run_crc_d   = '0;
        out_valid_d = 1'b1;
      end else begin
        run_crc_d = next_crc;
      end
    end
    if (s_fire) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_crc_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      run_crc_q   <= run_crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_data_q  <= s_axis_tdata[WordWidth-1:0];
      in_count_q <= s_axis_tdata[WordWidth +: CountWidth];
      in_last_q  <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_crc_q <= next_crc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;

endmodule

`default_nettype wire

// ===== rtl/core/crcws_absorb.sv =====
// ---------------------------------------------------------------------------
// CRC-64 word absorb
// Folds the valid low-order bytes of one word into the running CRC.
// ---------------------------------------------------------------------------
`default_nettype none

module crcws_absorb (
  input  var crcws_pkg::crc_t   crc_i,
  input  var crcws_pkg::word_t  data_i,
  input  var crcws_pkg::count_t count_i,
  output var crcws_pkg::crc_t   crc_o
);
  import crcws_pkg::*;

  // Counts above the word size take every byte; the compare saturates naturally.
  always_comb begin
    crc_t c;
    c = crc_i;
    for (int k = 0; k < WordBytes; k++) begin
      if (CountWidth'(k) < count_i) begin
        c = absorb_byte(c, data_i[8*k +: 8]);
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcws_checker.sv =====
// ---------------------------------------------------------------------------
// CRC-64 word stream port checker
// Port-level checks on the stream unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module crcws_checker (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic                              s_axis_tvalid,
  input  var logic                              s_axis_tready,
  input  var logic [crcws_pkg::InDataWidth-1:0] s_axis_tdata,
  input  var logic                              s_axis_tlast,
  input  var logic                              m_axis_tvalid,
  input  var logic                              m_axis_tready,
  input  var crcws_pkg::crc_t                   m_axis_tdata
);
  import crcws_pkg::*;

  // result holds until taken
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with output free");

  // release the input only once the result side takes the waiting CRC
  a_stall_persist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tready |=> !s_axis_tready || m_axis_tready)
    else $error("input released while result still blocked");

  // an offered word holds until taken
  a_in_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input word changed before it was taken");

endmodule

bind crc64_reflected_word_stream_unit crcws_checker u_crcws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/crc64_word_stream_checker.sv =====
// ---------------------------------------------------------------------------
// CRC-64 word stream checker
// Watches both stream channels of the CRC-64 word stream unit, folds every
// accepted word into its own running CRC and compares each finished CRC that
// leaves the block with the oldest CRC still owed.
// ---------------------------------------------------------------------------
`default_nettype none

module crc64_word_stream_checker
  import crcws_pkg::*;
(
  input  var logic                   clk_i,
  input  var logic                   rst_ni,
  input  var logic                   word_valid_i,
  input  var logic                   word_ready_i,
  // [63:0] data_word, [67:64] byte_count, [71:68] zero
  input  var logic [InDataWidth-1:0] word_data_i,
  input  var logic                   word_last_i,
  input  var logic                   crc_valid_i,
  input  var logic                   crc_ready_i,
  // [63:0] crc_value
  input  var crc_t                   crc_data_i,
  output var int                     mismatches_o,
  output var int                     crcs_pending_o,
  output var int                     crcs_checked_o,
  output var int                     words_seen_o
);

  localparam crc_t Crc64PolyReflected = 64'hC96C5795D7870F42;

  crc_t running_crc = '0;
  crc_t expected_crcs[$];
  int   mismatches = 0;
  int   crcs_pending = 0;
  int   crcs_checked = 0;
  int   words_seen = 0;

  assign mismatches_o   = mismatches;
  assign crcs_pending_o = crcs_pending;
  assign crcs_checked_o = crcs_checked;
  assign words_seen_o   = words_seen;

  // Bit-serial reflected CRC: message bits enter LSB first, a byte count
  // above eight takes the whole word.
  function automatic crc_t crc64_fold_word(input crc_t crc, input word_t data,
                                           input count_t count);
    int unsigned nbytes;
    logic        feedback;
    nbytes = (count > WordBytes) ? WordBytes : count;
    for (int i = 0; i < 8 * nbytes; i++) begin
      feedback = crc[0] ^ data[i];
      crc = (crc >> 1) ^ (feedback ? Crc64PolyReflected : '0);
    end
    return crc;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] crc check: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    crc_t want;
    if (!rst_ni) begin
      running_crc = '0;
      expected_crcs.delete();
      crcs_pending = 0;
    end else begin
      // a CRC leaving now was closed on an earlier edge, so check it first
      if (crc_valid_i && crc_ready_i) begin
        if (expected_crcs.size() == 0) begin
          report_mismatch($sformatf("crc %h with no message closed", crc_data_i));
        end else begin
          want = expected_crcs.pop_front();
          crcs_checked++;
          if (crc_data_i !== want) begin
            report_mismatch($sformatf("crc_value %h, expected %h", crc_data_i, want));
          end
        end
      end
      if (word_valid_i && word_ready_i) begin
        words_seen++;
        running_crc = crc64_fold_word(running_crc, word_data_i[WordWidth-1:0],
                                      word_data_i[WordWidth +: CountWidth]);
        if (word_last_i) begin
          expected_crcs.push_back(running_crc);
          running_crc = '0;
        end
      end
      crcs_pending = expected_crcs.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// CRC-64 word stream unit testbench
// Feeds directed corner words and random messages with random gaps on both
// sides, holds the result side off once to fill the block, and lets the
// checker compare every finished CRC.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import crcws_pkg::*;

  localparam int unsigned RandomWords   = 750;
  localparam int unsigned HoldOffCycles = 256;
  localparam int unsigned HoldOffAfter  = 20;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned GapMax        = 9;
  localparam int unsigned PhaseWords    = 40;

  localparam logic [7:0] ByteTrue  = 8'h54;  // 'T'
  localparam logic [7:0] ByteFalse = 8'h46;  // 'F'

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [63:0] data_word, [67:64] byte_count, [71:68] zero
  logic [InDataWidth-1:0] s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [63:0] crc_value
  crc_t                   m_axis_tdata;

  int mismatches;
  int crcs_pending;
  int crcs_checked;
  int words_seen;

  int unsigned messages_sent = 0;
  int unsigned src_words = 0;
  logic        src_steady = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  crc64_reflected_word_stream_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  crc64_word_stream_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_valid_i   (s_axis_tvalid),
    .word_ready_i   (s_axis_tready),
    .word_data_i    (s_axis_tdata),
    .word_last_i    (s_axis_tlast),
    .crc_valid_i    (m_axis_tvalid),
    .crc_ready_i    (m_axis_tready),
    .crc_data_i     (m_axis_tdata),
    .mismatches_o   (mismatches),
    .crcs_pending_o (crcs_pending),
    .crcs_checked_o (crcs_checked),
    .words_seen_o   (words_seen)
  );

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input word_t data, input count_t count, input logic last);
    int unsigned gap;
    if (src_words % PhaseWords == 0) begin
      src_steady = ($urandom_range(0, 3) == 0);
    end
    src_words++;
    gap = src_steady ? 0 : $urandom_range(0, GapMax);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataWidth - WordWidth - CountWidth){1'b0}}, count, data};
    s_axis_tlast  <= last;
    if (last) begin
      messages_sent++;
    end
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Result side: random stalls, steady stretches, and one long hold-off.
  initial begin : crc_sink
    int unsigned gap;
    int unsigned crcs_taken;
    logic        steady;
    crcs_taken = 0;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (crcs_taken % PhaseWords == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (crcs_taken == HoldOffAfter) begin
        gap = HoldOffCycles;
      end else begin
        gap = steady ? 0 : $urandom_range(0, GapMax);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      crcs_taken++;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[%0t] no word moved for %0d cycles", $time, StallLimit);
    $display("crc64_reflected_word_stream_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned kind;
    int unsigned nwords;
    count_t      count;
    logic        last;
    random_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner words
    send_word('0, 4'd0, 1'b1);                        // empty message
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd8, 1'b1);
    for (int c = 1; c <= 8; c++) begin
      send_word({$urandom, $urandom}, count_t'(c), 1'b1);
    end
    send_word({$urandom, $urandom}, 4'd15, 1'b0);      // saturates to eight
    send_word({$urandom, $urandom}, 4'd9, 1'b1);
    send_word({$urandom, $urandom}, 4'd0, 1'b0);       // absorbs nothing
    send_word({$urandom, $urandom}, 4'd3, 1'b0);
    send_word({$urandom, $urandom}, 4'd0, 1'b1);       // closes with no bytes
    // little-endian 32-bit field followed by a flag byte
    send_word({24'h0, ByteTrue, 32'h1234_5678}, 4'd5, 1'b1);
    send_word({56'h0, ByteFalse}, 4'd1, 1'b1);
    send_word({$urandom, $urandom}, 4'd10, 1'b0);
    send_word({$urandom, $urandom}, 4'd11, 1'b0);
    send_word({$urandom, $urandom}, 4'd12, 1'b0);
    send_word({$urandom, $urandom}, 4'd13, 1'b0);
    send_word({$urandom, $urandom}, 4'd14, 1'b1);

    // mostly well-formed messages, some long ones, and stray words
    while (random_sent < RandomWords) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        count = count_t'($urandom_range(0, 15));
        last  = 1'($urandom_range(0, 1));
        send_word({$urandom, $urandom}, count, last);
        if (count != 0 || last) begin
          random_sent++;
        end
      end else begin
        nwords = (kind == 1) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (int w = 0; w < nwords; w++) begin
          last = (w == nwords - 1);
          count = last ? count_t'($urandom_range(1, 8)) : count_t'(WordBytes);
          send_word({$urandom, $urandom}, count, last);
        end
        random_sent += nwords;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (crcs_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d words in %0d messages, %0d crcs compared,", words_seen,
             messages_sent, crcs_checked);
    $display("including byte counts 0..15, empty messages and a %0d-cycle output hold-off",
             HoldOffCycles);
    if (mismatches == 0 && crcs_pending == 0) begin
      $display("crc64_reflected_word_stream_unit regression: pass");
    end else begin
      $display("crc64_reflected_word_stream_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
